// ----- rtl/core/cdq_pkg.sv -----
// package with the constants, codes and types of the circular deque
`default_nettype none

package cdq_pkg;

  localparam int DEPTH  = 128;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CAP_W  = 8;
  localparam int EFF_W  = IDX_W + 1;
  localparam int DATA_W = 32;
  localparam int MODE_W = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_REAR  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_REAR   = 3'd3,
    MODE_PEEK       = 3'd4
  } mode_t;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [EFF_W-1:0]  eff_cap_t;
  typedef logic [CAP_W-1:0]  cap_t;
  typedef logic signed [DATA_W-1:0] data_t;

endpackage

`default_nettype wire

// ----- rtl/core/cdq_if.sv -----
// valid/ready channel interfaces for request, response and configuration words
`default_nettype none

interface cdq_req_if;
  import cdq_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  data_t               value;
  modport source (output valid, output mode, output value, input ready);
  modport sink (input valid, input mode, input value, output ready);
endinterface

interface cdq_rsp_if;
  import cdq_pkg::*;
  logic  valid;
  logic  ready;
  logic  error;
  logic  is_empty;
  logic  is_full;
  data_t front_value;
  data_t rear_value;
  modport source (output valid, output error, output is_empty, output is_full,
                  output front_value, output rear_value, input ready);
  modport sink (input valid, input error, input is_empty, input is_full,
                input front_value, input rear_value, output ready);
endinterface

interface cdq_cfg_if;
  import cdq_pkg::*;
  logic valid;
  logic ready;
  cap_t capacity;
  modport source (output valid, output capacity, input ready);
  modport sink (input valid, input capacity, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/circular_deque_top.sv -----
// circular deque with its entries in a two-read, one-write synchronous memory
//
//  channel | dir | word
//  --------+-----+-----------------------------------------------------------
//  req     | in  | mode, value
//  rsp     | out | error, is_empty, is_full, front_value, rear_value
//  cfg     | in  | capacity (always ready, also empties the deque)
//
//  for each word, the accept cycle updates the indices and writes
//  the memory, the next cycle takes the registered reads of head and tail
//  into the response register; a new word waits while busy is set, and
//  the next word is taken in the cycle its predecessor's response is taken
//  reset empties the deque and sets capacity to the full depth; memory
//  contents are not cleared
`default_nettype none

module circular_deque_top (
  input wire logic clk,
  input wire logic rst,
  cdq_req_if.sink   req,
  cdq_rsp_if.source rsp,
  cdq_cfg_if.sink   cfg
);
  import cdq_pkg::*;

  data_t mem [DEPTH];

  cap_t     capacity;
  idx_t     head;
  idx_t     tail;
  logic     empty_mark;
  logic     busy;

  idx_t     head_next;
  idx_t     tail_next;
  logic     empty_next;
  logic     we;
  idx_t     waddr;
  logic     err_next;
  logic     full_next;
  logic     full_now;
  eff_cap_t cap_eff;
  logic     req_acc;
  logic     cfg_acc;

  logic     pend_err;
  logic     pend_empty;
  logic     pend_full;
  logic     hit_front;
  logic     hit_rear;
  data_t    fwd_data;
  data_t    rd_front;
  data_t    rd_rear;

  logic     out_valid;
  logic     out_error;
  logic     out_empty;
  logic     out_full;
  data_t    out_front;
  data_t    out_rear;

  function automatic idx_t idx_inc(input idx_t x, input eff_cap_t c);
    eff_cap_t s;
    s = {1'b0, x} + EFF_W'(1);
    return (s >= c) ? '0 : s[IDX_W-1:0];
  endfunction

  function automatic idx_t idx_dec(input idx_t x, input eff_cap_t c);
    eff_cap_t m;
    m = c - EFF_W'(1);
    return (x == '0) ? m[IDX_W-1:0] : x - IDX_W'(1);
  endfunction

  assign cfg.ready = 1'b1;
  assign cfg_acc   = cfg.valid && cfg.ready;
  assign req.ready = !busy && (!out_valid || rsp.ready);
  assign req_acc   = req.valid && req.ready;

  always_comb begin
    if (capacity == '0) begin
      cap_eff = EFF_W'(1);
    end else if (capacity > CAP_W'(DEPTH)) begin
      cap_eff = EFF_W'(DEPTH);
    end else begin
      cap_eff = capacity[EFF_W-1:0];
    end
  end

  assign full_now = !empty_mark && (idx_inc(tail, cap_eff) == head);

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    empty_next = empty_mark;
    we         = 1'b0;
    waddr      = '0;
    err_next   = 1'b0;
    case (mode_t'(req.mode))
      MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
        if (full_now) begin
          err_next = 1'b1;
        end else if (empty_mark) begin
          head_next  = '0;
          tail_next  = '0;
          empty_next = 1'b0;
          we         = 1'b1;
        end else if (mode_t'(req.mode) == MODE_PUSH_FRONT) begin
          head_next = idx_dec(head, cap_eff);
          we        = 1'b1;
          waddr     = head_next;
        end else begin
          tail_next = idx_inc(tail, cap_eff);
          we        = 1'b1;
          waddr     = tail_next;
        end
      end
      MODE_POP_FRONT, MODE_POP_REAR: begin
        if (empty_mark) begin
          err_next = 1'b1;
        end else if (head == tail) begin
          head_next  = '0;
          tail_next  = '0;
          empty_next = 1'b1;
        end else if (mode_t'(req.mode) == MODE_POP_FRONT) begin
          head_next = idx_inc(head, cap_eff);
        end else begin
          tail_next = idx_dec(tail, cap_eff);
        end
      end
      default: begin
      end
    endcase
  end

  assign full_next = !empty_next && (idx_inc(tail_next, cap_eff) == head_next);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= CAP_RESET;
      head       <= '0;
      tail       <= '0;
      empty_mark <= 1'b1;
      busy       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_acc) begin
        capacity   <= cfg.capacity;
        head       <= '0;
        tail       <= '0;
        empty_mark <= 1'b1;
      end else if (req_acc) begin
        head       <= head_next;
        tail       <= tail_next;
        empty_mark <= empty_next;
      end
      busy <= req_acc;
      if (busy) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // entry store with write forwarding
  always_ff @(posedge clk) begin
    if (req_acc && we) begin
      mem[waddr] <= req.value;
    end
    rd_front   <= mem[head_next];
    rd_rear    <= mem[tail_next];
    fwd_data   <= req.value;
    hit_front  <= req_acc && we && (waddr == head_next);
    hit_rear   <= req_acc && we && (waddr == tail_next);
    pend_err   <= err_next;
    pend_empty <= empty_next;
    pend_full  <= full_next;
  end

  // response register
  always_ff @(posedge clk) begin
    if (busy) begin
      out_error <= pend_err;
      out_empty <= pend_empty;
      out_full  <= pend_full;
      out_front <= pend_empty ? '1 : (hit_front ? fwd_data : rd_front);
      out_rear  <= pend_empty ? '1 : (hit_rear ? fwd_data : rd_rear);
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.error       = out_error;
  assign rsp.is_empty    = out_empty;
  assign rsp.is_full     = out_full;
  assign rsp.front_value = out_front;
  assign rsp.rear_value  = out_rear;

endmodule

`default_nettype wire
